// ===== rtl/vertex_perspective_project_top_macros.svh =====
// assertion macros for the vertex projection top level
`ifndef VERTEX_PERSPECTIVE_PROJECT_TOP_MACROS_SVH
`define VERTEX_PERSPECTIVE_PROJECT_TOP_MACROS_SVH

// checked only outside reset
`define VPP_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define VPP_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vpp_pkg.sv =====
// constants shared by the vertex projection pipeline
`default_nettype none
package vpp_pkg;

  localparam int DIM_W       = 13;
  localparam int SCALE_MIN_W = 18;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;

  localparam int X_SCALE_RST      = -41243;
  localparam int Y_SCALE_RST      = -54991;
  localparam int DEPTH_SCALE_RST  = 66873;
  localparam int DEPTH_OFFSET_RST = 66873;

  localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  // pipeline advance control handed to every stage group
  typedef struct packed {
    logic en;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/vpp_front.sv =====
// projection multiplies, clamping and depth mapping
`default_nettype none
module vpp_front #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int SCW = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vpp_pkg::stage_ctl_t ctl,
  input  wire logic                in_valid,
  input  wire logic [W-1:0]        pos_x,
  input  wire logic [W-1:0]        pos_y,
  input  wire logic [W-1:0]        pos_z,
  input  wire logic [SCW-1:0]      x_scale,
  input  wire logic [SCW-1:0]      y_scale,
  input  wire logic [SCW-1:0]      depth_scale,
  input  wire logic [SCW-1:0]      depth_offset,
  output logic                     out_valid,
  output logic [W-1:0]             x,
  output logic [W-1:0]             y,
  output logic [W-1:0]             z,
  output logic [W-1:0]             w,
  output logic                     wzero,
  output logic                     sat,
  output logic [2:0]               neg,
  output logic [2:0][W-1:0]        mag,
  output logic [W-1:0]             den
);

  localparam int PW = W + SCW;
  localparam int SN = SCW + 1;
  localparam logic [PW-1:0] LIMP = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SN-1:0] SMAX = {{(SN-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SN-1:0] SMIN = {{(SN-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
    mag_w = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [SCW-1:0] mag_s(input logic [SCW-1:0] v);
    mag_s = v[SCW-1] ? (~v + 1'b1) : v;
  endfunction

  // shift magnitude down, clamp, apply sign; bit W is the clamp flag
  function automatic logic [W:0] clamp_prod(input logic n, input logic [PW-1:0] p);
    logic [PW-1:0] v;
    logic          over;
    logic [W-1:0]  r;
    v    = p >> F;
    over = n ? (v > LIMP + 1'b1) : (v > LIMP);
    r    = over ? (n ? {1'b1, {(W-1){1'b0}}} : LIMP[W-1:0]) : v[W-1:0];
    clamp_prod = {over, n ? (~r + 1'b1) : r};
  endfunction

  function automatic logic [W:0] clamp_sum(input logic [SN-1:0] s);
    if ($signed(s) > $signed(SMAX)) clamp_sum = {1'b1, SMAX[W-1:0]};
    else if ($signed(s) < $signed(SMIN)) clamp_sum = {1'b1, SMIN[W-1:0]};
    else clamp_sum = {1'b0, s[W-1:0]};
  endfunction

  // stage a: magnitude products
  logic          a_valid;
  logic [PW-1:0] a_px, a_py, a_pz;
  logic          a_nx, a_ny, a_nz;
  logic [W-1:0]  a_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (ctl.en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      a_px <= PW'(mag_w(pos_x)) * PW'(mag_s(x_scale));
      a_py <= PW'(mag_w(pos_y)) * PW'(mag_s(y_scale));
      a_pz <= PW'(mag_w(pos_z)) * PW'(mag_s(depth_scale));
      a_nx <= pos_x[W-1] ^ x_scale[SCW-1];
      a_ny <= pos_y[W-1] ^ y_scale[SCW-1];
      a_nz <= pos_z[W-1] ^ depth_scale[SCW-1];
      a_w  <= pos_z;
    end
  end

  // stage b: shift and clamp
  logic         b_valid;
  logic [W-1:0] b_x, b_y, b_zm, b_w;
  logic         b_sat;
  logic [W:0]   cx, cy, cz;

  always_comb begin
    cx = clamp_prod(a_nx, a_px);
    cy = clamp_prod(a_ny, a_py);
    cz = clamp_prod(a_nz, a_pz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (ctl.en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      b_x   <= cx[W-1:0];
      b_y   <= cy[W-1:0];
      b_zm  <= cz[W-1:0];
      b_w   <= a_w;
      b_sat <= cx[W] | cy[W] | cz[W];
    end
  end

  // stage c: depth offset and divider operands
  logic [SN-1:0] zsum;
  logic [W:0]    zc;
  logic          wpos;

  always_comb begin
    zsum = {{(SN-W){b_zm[W-1]}}, b_zm} + {depth_offset[SCW-1], depth_offset};
    zc   = clamp_sum(zsum);
    wpos = ~b_w[W-1] & (b_w != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x      <= b_x;
      y      <= b_y;
      z      <= zc[W-1:0];
      w      <= b_w;
      wzero  <= (b_w == '0);
      sat    <= b_sat | zc[W];
      neg[0] <= b_x[W-1] ^ wpos;
      neg[1] <= b_y[W-1] ^ wpos;
      neg[2] <= zc[W-1] ^ wpos;
      mag[0] <= mag_w(b_x);
      mag[1] <= mag_w(b_y);
      mag[2] <= mag_w(zc[W-1:0]);
      den    <= mag_w(b_w);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vpp_div.sv =====
// three-lane restoring divider, one quotient bit per stage
`default_nettype none
module vpp_div #(
  parameter int W     = 32,
  parameter int F     = 16,
  parameter int SIDEW = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire vpp_pkg::stage_ctl_t   ctl,
  input  wire logic                  in_valid,
  input  wire logic [2:0][W-1:0]     num_in,
  input  wire logic [W-1:0]          den_in,
  input  wire logic [SIDEW-1:0]      side_in,
  output logic                       out_valid,
  output logic [2:0][W+F-1:0]        quo_out,
  output logic [SIDEW-1:0]           side_out
);

  localparam int Q = W + F;

  logic [W-1:0]     rem_r   [Q][3];
  logic [Q-1:0]     quo_r   [Q][3];
  logic [Q-1:0]     num_r   [Q][3];
  logic [W-1:0]     den_r   [Q];
  logic [SIDEW-1:0] side_r  [Q];
  logic [Q-1:0]     vld;

  logic [W-1:0]     rem_next [Q][3];
  logic [Q-1:0]     quo_next [Q][3];
  logic [Q-1:0]     num_next [Q][3];

  always_comb begin
    logic [W:0]   trial;
    logic [W-1:0] prem;
    logic [W-1:0] pden;
    logic [Q-1:0] pnum;
    logic [Q-1:0] pquo;
    for (int k = 0; k < Q; k++) begin
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          prem = '0;
          pnum = {num_in[l], {F{1'b0}}};
          pquo = '0;
          pden = den_in;
        end else begin
          prem = rem_r[k-1][l];
          pnum = num_r[k-1][l];
          pquo = quo_r[k-1][l];
          pden = den_r[k-1];
        end
        trial = {prem, pnum[Q-1-k]};
        if (trial >= {1'b0, pden}) begin
          rem_next[k][l] = W'(trial - {1'b0, pden});
          quo_next[k][l] = {pquo[Q-2:0], 1'b1};
        end else begin
          rem_next[k][l] = trial[W-1:0];
          quo_next[k][l] = {pquo[Q-2:0], 1'b0};
        end
        num_next[k][l] = pnum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.en) begin
      vld <= {vld[Q-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int k = 0; k < Q; k++) begin
        for (int l = 0; l < 3; l++) begin
          rem_r[k][l] <= rem_next[k][l];
          quo_r[k][l] <= quo_next[k][l];
          num_r[k][l] <= num_next[k][l];
        end
        den_r[k]  <= (k == 0) ? den_in : den_r[k-1];
        side_r[k] <= (k == 0) ? side_in : side_r[k-1];
      end
    end
  end

  always_comb begin
    out_valid = vld[Q-1];
    side_out  = side_r[Q-1];
    for (int l = 0; l < 3; l++) begin
      quo_out[l] = quo_r[Q-1][l];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vpp_back.sv =====
// quotient clamp, zero-w bypass and viewport mapping
`default_nettype none
module vpp_back #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire vpp_pkg::stage_ctl_t          ctl,
  input  wire logic                         in_valid,
  input  wire logic [2:0][W+F-1:0]          quo,
  input  wire logic [W-1:0]                 raw_x,
  input  wire logic [W-1:0]                 raw_y,
  input  wire logic [W-1:0]                 raw_z,
  input  wire logic [W-1:0]                 raw_w,
  input  wire logic                         raw_wzero,
  input  wire logic                         raw_sat,
  input  wire logic [2:0]                   neg,
  input  wire logic [vpp_pkg::DIM_W-1:0]    scr_w,
  input  wire logic [vpp_pkg::DIM_W-1:0]    scr_h,
  output logic                              out_valid,
  output logic [W-1:0]                      screen_x,
  output logic [W-1:0]                      screen_y,
  output logic [W-1:0]                      ndc_depth,
  output logic [W-1:0]                      clip_w,
  output logic                              w_was_zero,
  output logic                              saturated
);

  localparam int Q  = W + F;
  localparam int MW = W + vpp_pkg::DIM_W + 1;
  localparam int SW = W + F + 2;
  localparam logic [Q-1:0]  LIMQ = {{(Q-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] MMAX = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [MW-1:0] MMIN = {{(MW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic [W:0] clamp_quo(input logic n, input logic [Q-1:0] q);
    logic         over;
    logic [W-1:0] r;
    over = n ? (q > LIMQ + 1'b1) : (q > LIMQ);
    r    = over ? (n ? {1'b1, {(W-1){1'b0}}} : LIMQ[W-1:0]) : q[W-1:0];
    clamp_quo = {over, n ? (~r + 1'b1) : r};
  endfunction

  function automatic logic [W:0] clamp_mul(input logic [MW-1:0] p);
    if ($signed(p) > $signed(MMAX)) clamp_mul = {1'b1, MMAX[W-1:0]};
    else if ($signed(p) < $signed(MMIN)) clamp_mul = {1'b1, MMIN[W-1:0]};
    else clamp_mul = {1'b0, p[W-1:0]};
  endfunction

  function automatic logic [W:0] clamp_add(input logic [SW-1:0] s);
    if ($signed(s) > $signed(SMAX)) clamp_add = {1'b1, SMAX[W-1:0]};
    else if ($signed(s) < $signed(SMIN)) clamp_add = {1'b1, SMIN[W-1:0]};
    else clamp_add = {1'b0, s[W-1:0]};
  endfunction

  // stage d: quotient clamp or bypass
  logic         d_valid;
  logic [W-1:0] d_x, d_y, d_z, d_w;
  logic         d_wzero, d_sat;
  logic [W:0]   qx, qy, qz;

  always_comb begin
    qx = clamp_quo(neg[0], quo[0]);
    qy = clamp_quo(neg[1], quo[1]);
    qz = clamp_quo(neg[2], quo[2]);
  end

  // stage e: viewport multiplies
  logic                 e_valid;
  logic signed [MW-1:0] e_px, e_py;
  logic [W-1:0]         e_z, e_w;
  logic                 e_wzero, e_sat;

  // stage f: product clamp
  logic         f_valid;
  logic [W-1:0] f_x, f_y, f_z, f_w;
  logic         f_wzero, f_sat;
  logic [W:0]   mx, my;

  // stage g: half-size offset
  logic [SW-1:0] sx, sy;
  logic [W:0]    gx, gy;

  always_comb begin
    mx = clamp_mul(e_px);
    my = clamp_mul(e_py);
    sx = {{(SW-W){f_x[W-1]}}, f_x} + SW'({scr_w, {(F-1){1'b0}}});
    sy = {{(SW-W){f_y[W-1]}}, f_y} + SW'({scr_h, {(F-1){1'b0}}});
    gx = clamp_add(sx);
    gy = clamp_add(sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctl.en) begin
      d_valid   <= in_valid;
      e_valid   <= d_valid;
      f_valid   <= e_valid;
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      d_x     <= raw_wzero ? raw_x : qx[W-1:0];
      d_y     <= raw_wzero ? raw_y : qy[W-1:0];
      d_z     <= raw_wzero ? raw_z : qz[W-1:0];
      d_w     <= raw_w;
      d_wzero <= raw_wzero;
      d_sat   <= raw_sat | (~raw_wzero & (qx[W] | qy[W] | qz[W]));

      e_px    <= $signed(d_x) * $signed({1'b0, scr_w});
      e_py    <= $signed(d_y) * $signed({1'b0, scr_h});
      e_z     <= d_z;
      e_w     <= d_w;
      e_wzero <= d_wzero;
      e_sat   <= d_sat;

      f_x     <= mx[W-1:0];
      f_y     <= my[W-1:0];
      f_z     <= e_z;
      f_w     <= e_w;
      f_wzero <= e_wzero;
      f_sat   <= e_sat | mx[W] | my[W];

      screen_x   <= gx[W-1:0];
      screen_y   <= gy[W-1:0];
      ndc_depth  <= f_z;
      clip_w     <= f_w;
      w_was_zero <= f_wzero;
      saturated  <= f_sat | gx[W] | gy[W];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/vertex_perspective_project_top.sv =====
// vertex perspective projection and viewport mapping, top level
//
// usage
//   input channel in_valid/in_ready carries one vertex beat (pos_x, pos_y,
//   pos_z); output channel out_valid/out_ready carries one result beat
//   (screen_x, screen_y, ndc_depth, clip_w, w_was_zero, saturated)
//   configuration: cfg_write with cfg_index/cfg_data writes one register per
//   clock; the user must write only while the pipeline is empty (unchecked)
// pipeline depth
//   front stages a to c, the divider stages, back stages d to f and the
//   output register, at the default Q16.16; the divide by -w is a restoring
//   divider with one quotient bit per stage, which sets the divider depth
// throughput
//   one vertex per clock unless stalled; every stage advances together
// stall
//   when the output register holds an untaken beat the whole pipeline
//   freezes and in_ready drops; nothing is lost or repeated
// reset
//   rst is synchronous; it empties the pipeline and loads the default
//   projection factors and a 640x480 screen
`default_nettype none
`include "vertex_perspective_project_top_macros.svh"
module vertex_perspective_project_top #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [COORD_WIDTH-1:0]        pos_x,
  input  wire logic [COORD_WIDTH-1:0]        pos_y,
  input  wire logic [COORD_WIDTH-1:0]        pos_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [COORD_WIDTH-1:0]             screen_x,
  output logic [COORD_WIDTH-1:0]             screen_y,
  output logic [COORD_WIDTH-1:0]             ndc_depth,
  output logic [COORD_WIDTH-1:0]             clip_w,
  output logic                               w_was_zero,
  output logic                               saturated,
  input  wire logic                          cfg_write,
  input  wire logic [vpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  // scales keep enough bits for the default factors at any coordinate width
  localparam int SCW   = (W > vpp_pkg::SCALE_MIN_W) ? W : vpp_pkg::SCALE_MIN_W;
  localparam int SIDEW = 4 * W + 5;

  // configuration registers
  logic [SCW-1:0]            x_scale, y_scale, depth_scale, depth_offset;
  logic [vpp_pkg::DIM_W-1:0] screen_width, screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale       <= SCW'(vpp_pkg::X_SCALE_RST);
      y_scale       <= SCW'(vpp_pkg::Y_SCALE_RST);
      depth_scale   <= SCW'(vpp_pkg::DEPTH_SCALE_RST);
      depth_offset  <= SCW'(vpp_pkg::DEPTH_OFFSET_RST);
      screen_width  <= vpp_pkg::SCREEN_WIDTH_RST;
      screen_height <= vpp_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        vpp_pkg::CFG_X_SCALE:       x_scale       <= {{(SCW-W){cfg_data[W-1]}}, cfg_data};
        vpp_pkg::CFG_Y_SCALE:       y_scale       <= {{(SCW-W){cfg_data[W-1]}}, cfg_data};
        vpp_pkg::CFG_DEPTH_SCALE:   depth_scale   <= {{(SCW-W){cfg_data[W-1]}}, cfg_data};
        vpp_pkg::CFG_DEPTH_OFFSET:  depth_offset  <= {{(SCW-W){cfg_data[W-1]}}, cfg_data};
        vpp_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[vpp_pkg::DIM_W-1:0];
        vpp_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[vpp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // one global advance: the pipeline moves whenever the output slot frees
  vpp_pkg::stage_ctl_t ctl;
  assign ctl.en   = ~out_valid | out_ready;
  assign in_ready = ctl.en;

  // front end: projection products, depth map, divider operands
  logic              fr_valid;
  logic [W-1:0]      fr_x, fr_y, fr_z, fr_w, fr_den;
  logic              fr_wzero, fr_sat;
  logic [2:0]        fr_neg;
  logic [2:0][W-1:0] fr_mag;

  vpp_front #(.W(W), .F(F), .SCW(SCW)) u_front (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .in_valid     (in_valid),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .x_scale      (x_scale),
    .y_scale      (y_scale),
    .depth_scale  (depth_scale),
    .depth_offset (depth_offset),
    .out_valid    (fr_valid),
    .x            (fr_x),
    .y            (fr_y),
    .z            (fr_z),
    .w            (fr_w),
    .wzero        (fr_wzero),
    .sat          (fr_sat),
    .neg          (fr_neg),
    .mag          (fr_mag),
    .den          (fr_den)
  );

  // undivided values, w and flags ride beside the divider lanes
  logic                dv_valid;
  logic [2:0][W+F-1:0] dv_quo;
  logic [SIDEW-1:0]    dv_side;
  logic [W-1:0]        sd_x, sd_y, sd_z, sd_w;
  logic                sd_wzero, sd_sat;
  logic [2:0]          sd_neg;

  vpp_div #(.W(W), .F(F), .SIDEW(SIDEW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (fr_valid),
    .num_in    (fr_mag),
    .den_in    (fr_den),
    .side_in   ({fr_x, fr_y, fr_z, fr_w, fr_wzero, fr_sat, fr_neg}),
    .out_valid (dv_valid),
    .quo_out   (dv_quo),
    .side_out  (dv_side)
  );

  assign {sd_x, sd_y, sd_z, sd_w, sd_wzero, sd_sat, sd_neg} = dv_side;

  // back end: clamp or bypass the divide, then map to the screen
  vpp_back #(.W(W), .F(F)) u_back (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .in_valid   (dv_valid),
    .quo        (dv_quo),
    .raw_x      (sd_x),
    .raw_y      (sd_y),
    .raw_z      (sd_z),
    .raw_w      (sd_w),
    .raw_wzero  (sd_wzero),
    .raw_sat    (sd_sat),
    .neg        (sd_neg),
    .scr_w      (screen_width),
    .scr_h      (screen_height),
    .out_valid  (out_valid),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .ndc_depth  (ndc_depth),
    .clip_w     (clip_w),
    .w_was_zero (w_was_zero),
    .saturated  (saturated)
  );

  // zero-w flag must agree with the w carried to the output
  `VPP_CHECK(a_wzero_match, out_valid && w_was_zero |-> clip_w == '0, "w flag set with nonzero w")
  `VPP_CHECK(a_wnz_match, out_valid && !w_was_zero |-> clip_w != '0, "w flag clear with zero w")
  // a pipeline just out of reset holds no beat
  `VPP_CHECK_ALWAYS(a_reset_empty, rst |=> !out_valid, "output beat right after reset")

endmodule
`default_nettype wire
